// ----- hw/rtl/cdns_pkg.sv -----
// shared types, constants and answer-record helper for the dns responder
// no dependencies
`default_nettype none

package cdns_pkg;

    localparam int REPLY_BUFFER_BYTES = 256;
    localparam int IDX_W = $clog2(REPLY_BUFFER_BYTES + 1);
    localparam int NX_W = ((IDX_W > 8) ? IDX_W : 8) + 2;
    localparam int ANSWER_BYTES = 16;
    localparam int ANS_CNT_W = $clog2(ANSWER_BYTES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int HEADER_BYTES = 12;
    localparam int OFS_FLAGS = 2;
    localparam int OFS_QD_HI = 4;
    localparam int OFS_QD_LO = 5;
    localparam int OFS_AN_HI = 6;
    localparam int OFS_AN_LO = 7;

    localparam logic [7:0] OPCODE_MASK = 8'h78;
    localparam logic [7:0] QR_BIT = 8'h80;
    localparam logic [7:0] ANCOUNT_LO = 8'h01;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANSWER_IP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANSWER_TTL = 2'd1;
    localparam logic [31:0] TTL_RESET = 32'd300;

    localparam logic [2:0] VERDICT_SEND = 3'd0;
    localparam logic [2:0] VERDICT_TOO_SHORT = 3'd1;
    localparam logic [2:0] VERDICT_NOT_QUERY = 3'd2;
    localparam logic [2:0] VERDICT_NO_QUESTION = 3'd3;
    localparam logic [2:0] VERDICT_BAD_NAME = 3'd4;
    localparam logic [2:0] VERDICT_TOO_LONG = 3'd5;

    localparam logic [7:0] ANS_PTR_HI = 8'hC0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_last;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [2:0] verdict;
    } tx_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic [2:0] verdict;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [0:0] {
        BK_PASS,
        BK_ANSWER
    } back_state_t;

    function automatic logic [7:0] answer_byte(input logic [ANS_CNT_W-1:0] k,
                                               input logic [31:0] ip,
                                               input logic [31:0] ttl);
        logic [7:0] r;
        case (k)
            4'd0:    r = ANS_PTR_HI;
            4'd1:    r = 8'(HEADER_BYTES);
            4'd2:    r = 8'h00;
            4'd3:    r = 8'h01;
            4'd4:    r = 8'h00;
            4'd5:    r = 8'h01;
            4'd6:    r = ttl[31:24];
            4'd7:    r = ttl[23:16];
            4'd8:    r = ttl[15:8];
            4'd9:    r = ttl[7:0];
            4'd10:   r = 8'h00;
            4'd11:   r = 8'h04;
            4'd12:   r = ip[31:24];
            4'd13:   r = ip[23:16];
            4'd14:   r = ip[15:8];
            default: r = ip[7:0];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cdns_front.sv -----
// front end: accepts query bytes, patches the header, walks the name, judges the frame
// depends on cdns_pkg
`default_nettype none

module cdns_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cdns_pkg::rx_item_t s_data,
    input  wire cdns_pkg::q_status_t q_status,
    output logic                    push_valid,
    output cdns_pkg::q_entry_t      push_data
);
    import cdns_pkg::*;

    localparam logic [IDX_W-1:0] CAP = IDX_W'(REPLY_BUFFER_BYTES);
    localparam logic [IDX_W-1:0] WALK_END = IDX_W'(REPLY_BUFFER_BYTES - 1);
    localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(REPLY_BUFFER_BYTES - ANSWER_BYTES);
    localparam logic [IDX_W-1:0] HDR = IDX_W'(HEADER_BYTES);

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [IDX_W-1:0] next_label_reg, next_label_next;
    logic             name_ended_reg, name_ended_next;
    logic             opcode_nz_reg, opcode_nz_next;
    logic             qcount_nz_reg, qcount_nz_next;

    logic [IDX_W-1:0] i;
    logic [7:0]       b;
    logic [7:0]       ob;
    logic             walk;
    logic [NX_W-1:0]  nx;
    logic [2:0]       verdict;
    logic             xfer;

    assign i = byte_index_reg;
    assign b = s_data.rx_byte;
    assign s_ready = !q_status.full;
    assign xfer = s_valid && s_ready;

    always_comb begin
        ob = b;
        if (i == IDX_W'(OFS_FLAGS)) begin
            ob = b | QR_BIT;
        end else if (i == IDX_W'(OFS_AN_LO)) begin
            ob = ANCOUNT_LO;
        end else if (i == IDX_W'(OFS_AN_HI) || (i >= IDX_W'(8) && i < HDR)) begin
            ob = 8'h00;
        end
    end

    always_comb begin
        opcode_nz_next = (i == IDX_W'(OFS_FLAGS)) ? ((b & OPCODE_MASK) != 8'h00)
                                                  : opcode_nz_reg;
        qcount_nz_next = qcount_nz_reg
                       | ((i == IDX_W'(OFS_QD_HI) || i == IDX_W'(OFS_QD_LO)) && b != 8'h00);
        walk = (i >= HDR) && !name_ended_reg && (i == next_label_reg) && (i < WALK_END);
        name_ended_next = name_ended_reg | (walk && b == 8'h00);
        nx = NX_W'(i) + NX_W'(b) + NX_W'(1);
        next_label_next = next_label_reg;
        if (walk && b != 8'h00) begin
            next_label_next = (nx > NX_W'(CAP)) ? CAP : nx[IDX_W-1:0];
        end
        byte_index_next = (i < CAP) ? i + IDX_W'(1) : i;
    end

    always_comb begin
        if (byte_index_next <= HDR) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (opcode_nz_next) begin
            verdict = VERDICT_NOT_QUERY;
        end else if (!qcount_nz_next) begin
            verdict = VERDICT_NO_QUESTION;
        end else if (!name_ended_next) begin
            verdict = VERDICT_BAD_NAME;
        end else if (byte_index_next > LEN_MAX) begin
            verdict = VERDICT_TOO_LONG;
        end else begin
            verdict = VERDICT_SEND;
        end
    end

    assign push_valid = xfer;
    assign push_data.data = ob;
    assign push_data.frame_end = s_data.rx_last;
    assign push_data.verdict = s_data.rx_last ? verdict : VERDICT_SEND;

    always_ff @(posedge aclk) begin
        if (!aresetn || (xfer && s_data.rx_last)) begin
            byte_index_reg <= '0;
            next_label_reg <= HDR;
            name_ended_reg <= 1'b0;
            opcode_nz_reg  <= 1'b0;
            qcount_nz_reg  <= 1'b0;
        end else if (xfer) begin
            byte_index_reg <= byte_index_next;
            next_label_reg <= next_label_next;
            name_ended_reg <= name_ended_next;
            opcode_nz_reg  <= opcode_nz_next;
            qcount_nz_reg  <= qcount_nz_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cdns_queue.sv -----
// short fifo between the front and back ends
// depends on cdns_pkg
`default_nettype none

module cdns_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    input  wire cdns_pkg::q_entry_t push_data,
    input  wire logic               pop_en,
    output cdns_pkg::q_entry_t      pop_data,
    output cdns_pkg::q_status_t     q_status
);
    import cdns_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push_valid && !q_status.full;
    assign do_pop  = pop_en && !q_status.empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count missed a push");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("queue count missed a pop");

endmodule

`default_nettype wire

// ----- hw/rtl/cdns_back.sv -----
// back end: drains the queue into the output register and appends the answer record
// depends on cdns_pkg
`default_nettype none

module cdns_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cdns_pkg::q_entry_t  pop_data,
    input  wire cdns_pkg::q_status_t q_status,
    output logic                     pop_en,
    input  wire logic [31:0]         answer_ip,
    input  wire logic [31:0]         answer_ttl,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cdns_pkg::tx_item_t       m_data
);
    import cdns_pkg::*;

    back_state_t          state_reg, state_next;
    logic [ANS_CNT_W-1:0] ans_cnt_reg, ans_cnt_next;
    logic [2:0]           verdict_reg, verdict_next;
    logic                 m_valid_reg, m_valid_next;
    tx_item_t             m_data_reg, m_data_next;
    logic                 advance;
    logic                 ans_done;

    assign advance  = !m_valid_reg || m_ready;
    assign ans_done = (ans_cnt_reg == ANS_CNT_W'(ANSWER_BYTES - 1));
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_PASS: begin
                if (advance && !q_status.empty && pop_data.frame_end) begin
                    state_next = BK_ANSWER;
                end
            end
            BK_ANSWER: begin
                if (advance && ans_done) begin
                    state_next = BK_PASS;
                end
            end
            default: state_next = BK_PASS;
        endcase
    end

    always_comb begin
        pop_en       = 1'b0;
        ans_cnt_next = ans_cnt_reg;
        verdict_next = verdict_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            BK_PASS: begin
                if (advance && !q_status.empty) begin
                    pop_en       = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next.tx_byte = pop_data.data;
                    m_data_next.tx_last = 1'b0;
                    m_data_next.verdict = VERDICT_SEND;
                    verdict_next = pop_data.verdict;
                    ans_cnt_next = '0;
                end
            end
            BK_ANSWER: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    m_data_next.tx_byte = answer_byte(ans_cnt_reg, answer_ip, answer_ttl);
                    m_data_next.tx_last = ans_done;
                    m_data_next.verdict = ans_done ? verdict_reg : VERDICT_SEND;
                    ans_cnt_next = ans_done ? '0 : ans_cnt_reg + ANS_CNT_W'(1);
                end
            end
            default: begin
                ans_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        verdict_reg <= verdict_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_PASS;
            ans_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ans_cnt_reg <= ans_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_pop_in_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_ANSWER) |-> !pop_en)
        else $error("queue popped while appending answer");

    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_PASS) |-> (ans_cnt_reg == '0))
        else $error("answer counter not cleared");

    a_verdict_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.verdict != VERDICT_SEND) |-> m_data_reg.tx_last)
        else $error("verdict outside final byte");

    a_answer_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_ANSWER && ans_cnt_reg == '0 && advance)
        |=> (m_valid_reg && m_data_reg.tx_byte == ANS_PTR_HI && !m_data_reg.tx_last))
        else $error("answer record does not start with name pointer");

endmodule

`default_nettype wire

// ----- hw/rtl/captive_dns_a_responder.sv -----
// top level of the captive dns responder: config registers, front end, queue, back end
// depends on cdns_pkg, cdns_front, cdns_queue, cdns_back
//
// Takes a dns query one byte per cycle on s_ while the queue is not full and
// returns it on m_ with the QR bit set and the answer, authority and additional
// counts rewritten to 1, 0, 0, then a 16-byte A record (pointer to offset 12,
// type A, class IN, answer_ttl, answer_ip). The final reply byte carries tx_last
// and the verdict; any nonzero verdict means the reply must be discarded. A query
// of N bytes gives N + 16 reply bytes at one byte per cycle while m_ready is high;
// the output register paces the reply and the four-entry queue lets the input
// run ahead until it fills while the answer record goes out. No clearing pass
// after reset. Write answer_ip (index 0) and answer_ttl (index 1) only while idle.
`default_nettype none

module captive_dns_a_responder (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire cdns_pkg::rx_item_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cdns_pkg::tx_item_t                m_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [cdns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                  cfg_data
);
    import cdns_pkg::*;

    logic [31:0] answer_ip_reg;
    logic [31:0] answer_ttl_reg;
    q_entry_t    push_data, pop_data;
    q_status_t   q_status;
    logic        push_valid, pop_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            answer_ip_reg  <= '0;
            answer_ttl_reg <= TTL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ANSWER_IP:  answer_ip_reg  <= cfg_data;
                CFG_ANSWER_TTL: answer_ttl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cdns_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    cdns_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_en     (pop_en),
        .pop_data   (pop_data),
        .q_status   (q_status)
    );

    cdns_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_data   (pop_data),
        .q_status   (q_status),
        .pop_en     (pop_en),
        .answer_ip  (answer_ip_reg),
        .answer_ttl (answer_ttl_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ----- sim/captive_dns_a_responder_test.sv -----
// testbench for captive_dns_a_responder: random and directed dns queries, byte-level reply check
// depends on cdns_pkg and the captive_dns_a_responder rtl; self-checking, no files or arguments
`timescale 1ns / 100ps

module captive_dns_a_responder_test;
    import cdns_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    typedef enum int {
        Q_GOOD,
        Q_BAD_OPCODE,
        Q_NO_QUESTION,
        Q_NO_END,
        Q_SHORT,
        Q_NOISE
    } query_kind_t;

    class reply_scoreboard;
        logic [31:0] ip;
        logic [31:0] ttl;
        logic [8:0]  byte_count;
        logic [8:0]  label_pos;
        logic        name_done;
        logic        op_seen;
        logic        qd_seen;
        tx_item_t    expected_q[$];
        int          errors;
        int          replies;
        int          frames;
        int          verdict_tally[6];

        function new();
            ip = '0;
            ttl = TTL_RESET;
            errors = 0;
            replies = 0;
            frames = 0;
            foreach (verdict_tally[k]) verdict_tally[k] = 0;
            clear_query();
        endfunction

        function void clear_query();
            byte_count = '0;
            label_pos = 9'(HEADER_BYTES);
            name_done = 1'b0;
            op_seen = 1'b0;
            qd_seen = 1'b0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_ANSWER_IP:  ip = val;
                CFG_ANSWER_TTL: ttl = val;
                default: ;
            endcase
        endfunction

        function void note_query_byte(rx_item_t it);
            logic [7:0]   b;
            logic [7:0]   ob;
            logic [8:0]   pos;
            logic [9:0]   nx;
            logic [2:0]   v;
            logic [127:0] rec;
            tx_item_t     t;
            b = it.rx_byte;
            ob = b;
            pos = byte_count;
            if (pos == OFS_FLAGS) begin
                op_seen = (b & OPCODE_MASK) != 0;
                ob = b | QR_BIT;
            end else if (pos == OFS_QD_HI || pos == OFS_QD_LO) begin
                if (b != 0) qd_seen = 1'b1;
            end else if (pos == OFS_AN_LO) begin
                ob = ANCOUNT_LO;
            end else if (pos == OFS_AN_HI || (pos > OFS_AN_LO && pos < HEADER_BYTES)) begin
                ob = 8'h00;
            end
            // name walk, limited to the receive window
            if (pos >= HEADER_BYTES && !name_done && pos == label_pos
                    && pos + 1 < REPLY_BUFFER_BYTES) begin
                if (b == 0) begin
                    name_done = 1'b1;
                end else begin
                    nx = 10'(pos) + 10'(b) + 10'd1;
                    label_pos = (nx > REPLY_BUFFER_BYTES) ? 9'(REPLY_BUFFER_BYTES) : nx[8:0];
                end
            end
            if (byte_count < REPLY_BUFFER_BYTES) byte_count = byte_count + 9'd1;
            t.tx_byte = ob;
            t.tx_last = 1'b0;
            t.verdict = VERDICT_SEND;
            expected_q = {expected_q, t};
            if (it.rx_last) begin
                if (byte_count <= HEADER_BYTES) v = VERDICT_TOO_SHORT;
                else if (op_seen) v = VERDICT_NOT_QUERY;
                else if (!qd_seen) v = VERDICT_NO_QUESTION;
                else if (!name_done) v = VERDICT_BAD_NAME;
                else if (byte_count + ANSWER_BYTES > REPLY_BUFFER_BYTES) v = VERDICT_TOO_LONG;
                else v = VERDICT_SEND;
                rec = {ANS_PTR_HI, 8'(HEADER_BYTES), 16'h0001, 16'h0001, ttl, 16'h0004, ip};
                for (int k = 0; k < ANSWER_BYTES; k++) begin
                    t.tx_byte = rec[127 - 8 * k -: 8];
                    t.tx_last = (k == ANSWER_BYTES - 1);
                    t.verdict = (k == ANSWER_BYTES - 1) ? v : VERDICT_SEND;
                    expected_q = {expected_q, t};
                end
                frames++;
                clear_query();
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 200) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_reply(tx_item_t got);
            tx_item_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected reply byte %02h last %0b verdict %0d",
                                          got.tx_byte, got.tx_last, got.verdict));
            end else begin
                want = expected_q.pop_front();
                replies++;
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("reply byte %0d: tx_byte %02h, want %02h",
                                              replies, got.tx_byte, want.tx_byte));
                if (got.tx_last !== want.tx_last)
                    report_mismatch($sformatf("reply byte %0d: tx_last %b, want %b",
                                              replies, got.tx_last, want.tx_last));
                if (got.verdict !== want.verdict)
                    report_mismatch($sformatf("reply byte %0d: verdict %0d, want %0d",
                                              replies, got.verdict, want.verdict));
                if (want.tx_last) verdict_tally[want.verdict]++;
            end
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    rx_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    tx_item_t               m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    reply_scoreboard sb;
    bit              quiet = 1'b0;
    int              cycles = 0;
    int              sent_bytes = 0;
    int              random_bytes = 0;
    int              rotation = 0;

    captive_dns_a_responder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // reply side: random backpressure, check every transfer
    initial begin
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_reply(m_data);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_query_byte(logic [7:0] b, logic last);
        int       gap;
        rx_item_t it;
        gap = pick_gap();
        it.rx_byte = b;
        it.rx_last = last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_query_byte(it);
        sent_bytes++;
    endtask

    task automatic send_frame(logic [7:0] q[$]);
        foreach (q[k]) send_query_byte(q[k], k == q.size() - 1);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_answer(logic [31:0] ip, logic [31:0] ttl);
        wait_idle();
        write_reg(CFG_ANSWER_IP, ip);
        write_reg(CFG_ANSWER_TTL, ttl);
    endtask

    task automatic send_random_query(query_kind_t kind);
        logic [7:0] q[$];
        int         labels;
        int         n;
        if (kind == Q_SHORT || kind == Q_NOISE) begin
            n = (kind == Q_SHORT) ? $urandom_range(1, HEADER_BYTES) : $urandom_range(1, 40);
            repeat (n) q = {q, 8'($urandom)};
        end else begin
            repeat (HEADER_BYTES) q = {q, 8'($urandom)};
            q[OFS_FLAGS] = q[OFS_FLAGS] & ~OPCODE_MASK;
            if (kind == Q_BAD_OPCODE) q[OFS_FLAGS] |= 8'($urandom_range(1, 15)) << 3;
            if (kind == Q_NO_QUESTION) begin
                q[OFS_QD_HI] = 8'h00;
                q[OFS_QD_LO] = 8'h00;
            end else if ($urandom_range(3) != 0) begin
                q[OFS_QD_HI] = 8'h00;
                q[OFS_QD_LO] = 8'h01;
            end else if (q[OFS_QD_HI] == 0 && q[OFS_QD_LO] == 0) begin
                q[OFS_QD_LO] = 8'h01;
            end
            labels = (kind == Q_NO_END) ? $urandom_range(1, 3) : $urandom_range(0, 2);
            repeat (labels) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(10, 63) : $urandom_range(1, 4);
                q = {q, 8'(n)};
                repeat (n) q = {q, 8'($urandom)};
            end
            if (kind != Q_NO_END) begin
                q = {q, 8'h00};
                n = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : 4;
                repeat (n) q = {q, 8'($urandom)};
            end
        end
        random_bytes += q.size();
        send_frame(q);
    endtask

    task automatic run_random(int target);
        query_kind_t kind;
        int          r;
        while (random_bytes < target) begin
            if (rotation < 6) begin
                kind = query_kind_t'(rotation);
                rotation++;
            end else begin
                r = $urandom_range(99);
                if (r < 55) kind = Q_GOOD;
                else if (r < 65) kind = Q_BAD_OPCODE;
                else if (r < 73) kind = Q_NO_QUESTION;
                else if (r < 83) kind = Q_NO_END;
                else if (r < 90) kind = Q_SHORT;
                else kind = Q_NOISE;
            end
            send_random_query(kind);
        end
    endtask

    task automatic send_long_query(int len, logic [7:0] first_label, int zero_at);
        logic [7:0] q[$];
        repeat (len) q = {q, 8'($urandom)};
        q[OFS_FLAGS] = q[OFS_FLAGS] & ~OPCODE_MASK;
        q[OFS_QD_HI] = 8'h00;
        q[OFS_QD_LO] = 8'h01;
        q[HEADER_BYTES] = first_label;
        if (zero_at >= 0) q[zero_at] = 8'h00;
        send_frame(q);
    endtask

    initial begin
        logic [7:0] q[$];
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ANSWER_IP;
        cfg_data <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values of the registers, single-byte, header-only, all-ones header but for a zero opcode
        send_frame('{8'hFF});
        q = {};
        repeat (HEADER_BYTES) q = {q, 8'h00};
        send_frame(q);
        q = '{8'hFF, 8'hFF, 8'h87, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'hFF, 8'h00};
        send_frame(q);

        set_answer(32'hFFFF_FFFF, 32'h0000_0000);
        run_random(50);
        set_answer(32'h0000_0000, 32'hFFFF_FFFF);
        quiet = 1'b1;
        run_random(100);
        quiet = 1'b0;
        set_answer($urandom, $urandom);
        run_random(170);

        // first label runs past the buffer
        set_answer($urandom, $urandom);
        send_long_query(20, 8'hFF, -1);

        wait_idle();
        repeat (16) @(posedge aclk);
        $display("covered %0d queries, %0d query bytes in, %0d reply bytes checked",
                 sb.frames, sent_bytes, sb.replies);
        $display("verdicts: send %0d, short %0d, opcode %0d, no question %0d, name %0d, long %0d",
                 sb.verdict_tally[VERDICT_SEND], sb.verdict_tally[VERDICT_TOO_SHORT],
                 sb.verdict_tally[VERDICT_NOT_QUERY], sb.verdict_tally[VERDICT_NO_QUESTION],
                 sb.verdict_tally[VERDICT_BAD_NAME], sb.verdict_tally[VERDICT_TOO_LONG]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
